>>> design/bgd_pkg.sv
// Shared types and constants of the BGGR bilinear demosaic block.
package bgd_pkg;

   localparam int PIX_W   = 8;
   localparam int COL_W   = 9;
   localparam int ROW_W   = 12;
   localparam int FW_W    = 10;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   // Reset values of the geometry registers.
   localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 10'd316;
   localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 12'd208;

   // Smallest effective frame side.
   localparam int MIN_SIDE = 3;

   typedef logic [PIX_W-1:0] pix_type;

   // 3x3 neighborhood, indexed [row][column], row 0 on top.
   typedef logic [2:0][2:0][PIX_W-1:0] pix_window_type;

   // Color phase of the window center: {row odd, column odd}.
   typedef enum logic [1:0] {
      PHASE_BLUE    = 2'b00,
      PHASE_GREEN_B = 2'b01,
      PHASE_GREEN_R = 2'b10,
      PHASE_RED     = 2'b11
   } phase_type;

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
   } rgb_type;

endpackage

>>> design/bgd_interp.sv
// Bilinear color interpolation of one 3x3 Bayer neighborhood.
module bgd_interp (
   input  bgd_pkg::pix_window_type win,
   input  bgd_pkg::phase_type      phase,
   output bgd_pkg::rgb_type        rgb
);
   import bgd_pkg::*;

   logic [PIX_W+1:0] cross_sum;
   logic [PIX_W+1:0] corner_sum;
   logic [PIX_W:0]   horiz_sum;
   logic [PIX_W:0]   vert_sum;
   pix_type          cross_avg;
   pix_type          corner_avg;
   pix_type          horiz_avg;
   pix_type          vert_avg;

   // Neighbor sums around the center sample.
   always_comb begin
      horiz_sum  = {1'b0, win[1][0]} + {1'b0, win[1][2]};
      vert_sum   = {1'b0, win[0][1]} + {1'b0, win[2][1]};
      cross_sum  = {1'b0, horiz_sum} + {1'b0, vert_sum};
      corner_sum = {2'b00, win[0][0]} + {2'b00, win[0][2]}
                 + {2'b00, win[2][0]} + {2'b00, win[2][2]};
      horiz_avg  = horiz_sum[PIX_W:1];
      vert_avg   = vert_sum[PIX_W:1];
      cross_avg  = cross_sum[PIX_W+1:2];
      corner_avg = corner_sum[PIX_W+1:2];
   end

   // Pick the averages that match the color of the center sample.
   always_comb begin
      case (phase)
         PHASE_RED: begin
            rgb = '{red: win[1][1], green: cross_avg, blue: corner_avg};
         end
         PHASE_GREEN_R: begin
            rgb = '{red: horiz_avg, green: win[1][1], blue: vert_avg};
         end
         PHASE_GREEN_B: begin
            rgb = '{red: vert_avg, green: win[1][1], blue: horiz_avg};
         end
         default: begin
            rgb = '{red: corner_avg, green: cross_avg, blue: win[1][1]};
         end
      endcase
   end

endmodule

>>> design/bayer_bggr_bilinear_demosaic.sv
// Top level of the streaming BGGR bilinear demosaic block.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   raw_sample
//   rsp_      out        rsp_valid/rsp_ready   red, green, blue, out_col, out_row,
//                                              last_of_run, frame_end
//   csr_      in         csr_wr_en             csr_index, csr_wdata
//
// One raw sample is taken per cycle while the input stage can advance. A sample waits in
// the input stage, where the line store read returns, and moves on to the result register;
// each result then goes out on its own output transaction, so a center that puts out two to
// four pixels holds the input until its last pixel is taken. Reset clears the counters, the
// window and the geometry; the line store needs no clearing. A stalled output
// holds the input stage, which then drops req_ready.
module bayer_bggr_bilinear_demosaic #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bgd_pkg::PIX_W-1:0]             req_raw_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bgd_pkg::PIX_W-1:0]             rsp_red,
   output logic [bgd_pkg::PIX_W-1:0]             rsp_green,
   output logic [bgd_pkg::PIX_W-1:0]             rsp_blue,
   output logic [bgd_pkg::COL_W-1:0]             rsp_out_col,
   output logic [bgd_pkg::ROW_W-1:0]             rsp_out_row,
   output logic                                  rsp_last_of_run,
   output logic                                  rsp_frame_end,
   input  logic                                  csr_wr_en,
   input  logic [bgd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bgd_pkg::CSR_W-1:0]             csr_wdata
);
   import bgd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int EW = (WW > FW_W) ? WW : FW_W;
   localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
   localparam logic [EW-1:0] MIN_W_E = EW'(MIN_SIDE);
   localparam logic [ROW_W-1:0] MIN_H = ROW_W'(MIN_SIDE);

   // Geometry registers.
   logic [FW_W-1:0]  frame_width_ff;
   logic [ROW_W-1:0] frame_height_ff;
   logic [EW-1:0]    eff_w;
   logic [ROW_W-1:0] eff_h;

   // Position counters and their values at acceptance.
   logic [CW-1:0]    col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic [CW-1:0]    acc_col;
   logic [ROW_W-1:0] acc_row;
   logic [ROW_W:0]   row_pre;
   logic [ROW_W:0]   row_inc;
   logic [EW-1:0]    col_inc;
   logic             col_wrap;

   // Input stage.
   logic             s1_valid_ff;
   pix_type          s1_sample_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_emit;
   logic             s1_adv;
   logic             req_accept;

   // Line store: {older row, newer row} per column.
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] line_rd_ff;

   // Window columns c-2 and c-1, top to bottom.
   pix_type [5:0]    win_cols_ff;
   pix_window_type   win;
   phase_type        phase;
   rgb_type          rgb;

   // Result list built in the input stage.
   logic [CW-1:0]    cx;
   logic [ROW_W-1:0] cy;
   logic             x_lo, x_hi, y_lo, y_hi;
   logic [CW-1:0]    w_last;
   logic [ROW_W-1:0] h_last;
   logic [2:0][CW-1:0]    xs;
   logic [2:0][ROW_W-1:0] ys;

   // Result register and run sequencing.
   logic                  run_valid_ff;
   rgb_type               run_rgb_ff;
   logic [2:0][CW-1:0]    run_xs_ff;
   logic [2:0][ROW_W-1:0] run_ys_ff;
   logic [1:0]            run_nx_ff, run_ny_ff;
   logic                  run_xhi_ff, run_yhi_ff;
   logic [1:0]            run_xi_ff, run_yi_ff, run_k_ff;
   logic                  cur_xl, cur_yl, cur_last;
   logic                  out_done, run_free;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective geometry after clamping.
   always_comb begin
      eff_w = EW'(frame_width_ff);
      if (eff_w < MIN_W_E) eff_w = MIN_W_E;
      if (eff_w > MAX_W_E) eff_w = MAX_W_E;
      eff_h = (frame_height_ff < MIN_H) ? MIN_H : frame_height_ff;
   end

   // Handshake of the input stage and the result register.
   always_comb begin
      cur_xl   = (run_xi_ff == run_nx_ff - 2'd1);
      cur_yl   = (run_yi_ff == run_ny_ff - 2'd1);
      cur_last = (run_k_ff == 2'd3) || (cur_xl && cur_yl);
      out_done = run_valid_ff && rsp_ready && cur_last;
      run_free = !run_valid_ff || out_done;
      s1_emit  = (s1_col_ff >= CW'(2)) && (s1_row_ff >= ROW_W'(2));
      s1_adv   = s1_valid_ff && (!s1_emit || run_free);
      req_ready  = !s1_valid_ff || s1_adv;
      req_accept = req_valid && req_ready;
   end

   // Position of the arriving sample and of the next one.
   always_comb begin
      col_wrap = (EW'(col_cnt_ff) >= eff_w);
      acc_col  = col_wrap ? '0 : col_cnt_ff;
      row_pre  = col_wrap ? ({1'b0, row_cnt_ff} + 1'b1) : {1'b0, row_cnt_ff};
      acc_row  = (row_pre >= {1'b0, eff_h}) ? '0 : row_pre[ROW_W-1:0];
      col_inc  = EW'(acc_col) + 1'b1;
      row_inc  = {1'b0, acc_row} + 1'b1;
      if (col_inc >= eff_w) begin
         col_cnt_in = '0;
         row_cnt_in = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[ROW_W-1:0];
      end else begin
         col_cnt_in = col_inc[CW-1:0];
         row_cnt_in = acc_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (req_accept) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // Input stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_raw_sample;
         s1_col_ff    <= acc_col;
         s1_row_ff    <= acc_row;
      end
   end

   // Line store: read at acceptance, rows shift when the sample leaves the stage.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         line_rd_ff <= line_mem[acc_col];
      end
      if (s1_adv) begin
         line_mem[s1_col_ff] <= {line_rd_ff[PIX_W-1:0], s1_sample_ff};
      end
   end

   // Window shifts by one column for every sample that leaves the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_cols_ff <= '0;
      end else if (s1_adv) begin
         win_cols_ff <= {s1_sample_ff, line_rd_ff[PIX_W-1:0], line_rd_ff[2*PIX_W-1:PIX_W],
                         win_cols_ff[5], win_cols_ff[4], win_cols_ff[3]};
      end
   end

   always_comb begin
      win[0][0] = win_cols_ff[0];
      win[1][0] = win_cols_ff[1];
      win[2][0] = win_cols_ff[2];
      win[0][1] = win_cols_ff[3];
      win[1][1] = win_cols_ff[4];
      win[2][1] = win_cols_ff[5];
      win[0][2] = line_rd_ff[2*PIX_W-1:PIX_W];
      win[1][2] = line_rd_ff[PIX_W-1:0];
      win[2][2] = s1_sample_ff;
      cx        = s1_col_ff - 1'b1;
      cy        = s1_row_ff - 1'b1;
      phase     = phase_type'({cy[0], cx[0]});
   end

   bgd_interp u_interp (
      .win   (win),
      .phase (phase),
      .rgb   (rgb)
   );

   // Pixels owned by the center, border copies included.
   always_comb begin
      w_last = CW'(eff_w - 1'b1);
      h_last = eff_h - 1'b1;
      x_lo   = (cx == CW'(1));
      x_hi   = (EW'(cx) == eff_w - EW'(2));
      y_lo   = (cy == ROW_W'(1));
      y_hi   = (cy == eff_h - ROW_W'(2));
      xs[0]  = x_lo ? '0 : cx;
      xs[1]  = x_lo ? cx : w_last;
      xs[2]  = w_last;
      ys[0]  = y_lo ? '0 : cy;
      ys[1]  = y_lo ? cy : h_last;
      ys[2]  = h_last;
   end

   // Result register and run sequencing, column by column within each row, row after row.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         run_xi_ff    <= '0;
         run_yi_ff    <= '0;
         run_k_ff     <= '0;
      end else if (s1_adv && s1_emit) begin
         run_valid_ff <= 1'b1;
         run_xi_ff    <= '0;
         run_yi_ff    <= '0;
         run_k_ff     <= '0;
      end else if (out_done) begin
         run_valid_ff <= 1'b0;
      end else if (run_valid_ff && rsp_ready) begin
         run_k_ff <= run_k_ff + 1'b1;
         if (cur_xl) begin
            run_xi_ff <= '0;
            run_yi_ff <= run_yi_ff + 1'b1;
         end else begin
            run_xi_ff <= run_xi_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit) begin
         run_rgb_ff <= rgb;
         run_xs_ff  <= xs;
         run_ys_ff  <= ys;
         run_nx_ff  <= 2'd1 + {1'b0, x_lo} + {1'b0, x_hi};
         run_ny_ff  <= 2'd1 + {1'b0, y_lo} + {1'b0, y_hi};
         run_xhi_ff <= x_hi;
         run_yhi_ff <= y_hi;
      end
   end

   // Result outputs.
   always_comb begin
      rsp_valid       = run_valid_ff;
      rsp_red         = run_rgb_ff.red;
      rsp_green       = run_rgb_ff.green;
      rsp_blue        = run_rgb_ff.blue;
      rsp_out_col     = COL_W'(run_xs_ff[run_xi_ff]);
      rsp_out_row     = run_ys_ff[run_yi_ff];
      rsp_last_of_run = cur_last;
      rsp_frame_end   = run_xhi_ff && cur_xl && run_yhi_ff && cur_yl;
   end

   // The run indexes stay inside the pixel list of the current center.
   a_run_index: assert property (@(posedge clock) disable iff (reset)
      run_valid_ff |-> (run_xi_ff < run_nx_ff) && (run_yi_ff < run_ny_ff))
      else $error("run index beyond pixel list");

   // A line store write never hits the column that is read in the same cycle.
   a_mem_hazard: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && req_accept) |-> (s1_col_ff != acc_col))
      else $error("line store read and write collide");

   // An accepted transaction occupies the input stage in the next cycle.
   a_stage_fill: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted transaction lost");

   // The last pixel of the frame always closes its run.
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_last_of_run)
      else $error("frame end not on last result of run");

   // The stage column is always inside the effective width.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (EW'(s1_col_ff) < eff_w))
      else $error("column outside frame");

endmodule

>>> verif/tb.sv
// Testbench of the BGGR bilinear demosaic: a raw pixel stream checked against a predicted RGB stream.
`timescale 1ns / 100ps

module tb;
   import bgd_pkg::*;

   localparam int LINE_DEPTH     = 512;
   localparam int MAX_PIXELS     = 4;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int WIDE_SAMPLES   = 20;
   localparam int BUSY_PCT       = 83;
   localparam int MIXED_PCT      = 36;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_type;

   // One demosaiced pixel as it leaves the block.
   typedef struct packed {
      pix_type          red;
      pix_type          green;
      pix_type          blue;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last_of_run;
      logic             frame_end;
   } rgb_pixel_type;

   // Mirrors the line stores, the window and the raster position, and keeps the
   // pixels that the accepted samples still owe.
   class demosaic_tracker_type;
      pix_type          older_line [LINE_DEPTH];
      pix_type          newer_line [LINE_DEPTH];
      int unsigned      write_hits [LINE_DEPTH];
      pix_type          win [6];
      int unsigned      col_pos;
      int unsigned      row_pos;
      logic [FW_W-1:0]  width_reg;
      logic [ROW_W-1:0] height_reg;
      rgb_pixel_type    expected_pixels [$];
      int unsigned      mismatches;

      function new();
         foreach (older_line[i]) begin
            older_line[i] = '0;
            newer_line[i] = '0;
            write_hits[i] = 0;
         end
         foreach (win[i]) win[i] = '0;
         col_pos    = 0;
         row_pos    = 0;
         width_reg  = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         mismatches = 0;
      endfunction

      function int unsigned clamp_width(int unsigned w);
         if (w < MIN_SIDE) return MIN_SIDE;
         if (w > LINE_DEPTH) return LINE_DEPTH;
         return w;
      endfunction

      function int unsigned eff_width();
         return clamp_width(width_reg);
      endfunction

      function int unsigned eff_height();
         return (height_reg < MIN_SIDE) ? MIN_SIDE : height_reg;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         if (idx == REG_FRAME_WIDTH) width_reg = data[FW_W-1:0];
         else height_reg = data[ROW_W-1:0];
      endfunction

      // A new width is safe at a frame start, or when every line store entry it
      // reaches already holds data in both rows.
      function bit width_can_become(logic [FW_W-1:0] value);
         if (col_pos == 0 && row_pos == 0) return 1'b1;
         for (int i = 0; i < clamp_width(value); i++)
            if (write_hits[i] < 2) return 1'b0;
         return 1'b1;
      endfunction

      // Samples still needed to reach the end of the current frame.
      function int unsigned frame_left();
         int unsigned w, h, c, r;
         w = eff_width();
         h = eff_height();
         c = col_pos;
         r = row_pos;
         if (c >= w) begin
            c = 0;
            r++;
         end
         if (r >= h) r = 0;
         return (h - 1 - r) * w + (w - c);
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      // Note one accepted sample and queue the pixels of the window it completes.
      function void take_sample(pix_type s);
         int unsigned    w, h, c, r, cx, cy;
         int unsigned    cross_sum, corner_sum, horiz_sum, vert_sum;
         int unsigned    ys [3];
         int unsigned    xs [3];
         int unsigned    ny, nx, total;
         pix_window_type nb;
         pix_type        red_v, green_v, blue_v;
         phase_type      ph;
         rgb_pixel_type  px;

         w = eff_width();
         h = eff_height();
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         c = col_pos;
         r = row_pos;

         nb[0][0] = win[0];
         nb[1][0] = win[1];
         nb[2][0] = win[2];
         nb[0][1] = win[3];
         nb[1][1] = win[4];
         nb[2][1] = win[5];
         nb[0][2] = older_line[c];
         nb[1][2] = newer_line[c];
         nb[2][2] = s;

         if (c >= 2 && r >= 2) begin
            cx = c - 1;
            cy = r - 1;
            cross_sum  = nb[1][0] + nb[1][2] + nb[0][1] + nb[2][1];
            corner_sum = nb[0][0] + nb[0][2] + nb[2][0] + nb[2][2];
            horiz_sum  = nb[1][0] + nb[1][2];
            vert_sum   = nb[0][1] + nb[2][1];
            ph = phase_type'({cy[0], cx[0]});
            case (ph)
               PHASE_RED: begin
                  red_v   = nb[1][1];
                  green_v = pix_type'(cross_sum >> 2);
                  blue_v  = pix_type'(corner_sum >> 2);
               end
               PHASE_GREEN_R: begin
                  red_v   = pix_type'(horiz_sum >> 1);
                  green_v = nb[1][1];
                  blue_v  = pix_type'(vert_sum >> 1);
               end
               PHASE_GREEN_B: begin
                  red_v   = pix_type'(vert_sum >> 1);
                  green_v = nb[1][1];
                  blue_v  = pix_type'(horiz_sum >> 1);
               end
               default: begin
                  red_v   = pix_type'(corner_sum >> 2);
                  green_v = pix_type'(cross_sum >> 2);
                  blue_v  = nb[1][1];
               end
            endcase

            // Border rows and columns borrow the pixels of their neighbor center.
            ny = 0;
            nx = 0;
            if (cy == 1) begin
               ys[ny] = 0;
               ny++;
            end
            ys[ny] = cy;
            ny++;
            if (cy == h - 2) begin
               ys[ny] = h - 1;
               ny++;
            end
            if (cx == 1) begin
               xs[nx] = 0;
               nx++;
            end
            xs[nx] = cx;
            nx++;
            if (cx == w - 2) begin
               xs[nx] = w - 1;
               nx++;
            end

            // Narrow frames may own more pixels than fit; the tail is dropped.
            total = ny * nx;
            if (total > MAX_PIXELS) total = MAX_PIXELS;
            for (int k = 0; k < total; k++) begin
               px.red         = red_v;
               px.green       = green_v;
               px.blue        = blue_v;
               px.col         = COL_W'(xs[k % nx]);
               px.row         = ROW_W'(ys[k / nx]);
               px.last_of_run = (k == total - 1);
               px.frame_end   = (xs[k % nx] == w - 1) && (ys[k / nx] == h - 1);
               expected_pixels.push_back(px);
            end
         end

         older_line[c] = newer_line[c];
         newer_line[c] = s;
         if (write_hits[c] < 2) write_hits[c]++;
         win[0] = win[3];
         win[1] = win[4];
         win[2] = win[5];
         win[3] = nb[0][2];
         win[4] = nb[1][2];
         win[5] = s;

         col_pos = c + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      // Compare one accepted result transaction with the oldest pixel owed.
      function void match_pixel(rgb_pixel_type got);
         rgb_pixel_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b end=%0b",
                     $time, got.red, got.green, got.blue, got.col, got.row,
                     got.last_of_run, got.frame_end);
            return;
         end
         want = expected_pixels.pop_front();
         if (got !== want) begin
            mismatches++;
            $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b end=%0b",
                     $time, want.red, want.green, want.blue, want.col, want.row,
                     want.last_of_run, want.frame_end);
            $display("%0t:                 actual   r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b end=%0b",
                     $time, got.red, got.green, got.blue, got.col, got.row,
                     got.last_of_run, got.frame_end);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_raw_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PIX_W-1:0]     rsp_red;
   logic [PIX_W-1:0]     rsp_green;
   logic [PIX_W-1:0]     rsp_blue;
   logic [COL_W-1:0]     rsp_out_col;
   logic [ROW_W-1:0]     rsp_out_row;
   logic                 rsp_last_of_run;
   logic                 rsp_frame_end;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   demosaic_tracker_type tracker = new();
   idle_kind_type        idle_mode = IDLE_NONE;
   int                   hold_token = 0;
   int                   hold_seen = 0;
   int                   hold_left = 0;
   int                   quiet_cycles = 0;

   bayer_bggr_bilinear_demosaic #(.MAX_WIDTH(LINE_DEPTH)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_raw_sample  (req_raw_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_row     (rsp_out_row),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   // Result side: a requested hold-off wins, otherwise stall by the idle mode.
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < BUSY_PCT) ||
                        (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < MIXED_PCT));
      end
   end

   // Every accepted result transaction goes to the tracker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.match_pixel({rsp_red, rsp_green, rsp_blue, rsp_out_col, rsp_out_row,
                              rsp_last_of_run, rsp_frame_end});
   end

   // Stop a hung run once no transaction has moved for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d pixels outstanding",
                  $time, quiet_cycles, tracker.pending());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offer one sample, with random gaps ahead of it, and wait for acceptance.
   task automatic send_sample(input pix_type value);
      while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < BUSY_PCT) ||
             (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < MIXED_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_sample <= value;
      do @(posedge clock); while (!req_ready);
      tracker.take_sample(value);
   endtask

   // Stop offering samples until every owed pixel is back, then let the pipe settle.
   task automatic drain_pixels(input int tail);
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (tail) @(posedge clock);
   endtask

   // Write the height, and the width first when asked.
   task automatic set_geometry(input bit with_width, input logic [CSR_W-1:0] wdata,
                               input logic [CSR_W-1:0] hdata);
      if (with_width) begin
         csr_wr_en <= 1'b1;
         csr_index <= REG_FRAME_WIDTH;
         csr_wdata <= wdata;
         @(posedge clock);
         tracker.set_reg(REG_FRAME_WIDTH, wdata);
      end
      csr_wr_en <= 1'b1;
      csr_index <= REG_FRAME_HEIGHT;
      csr_wdata <= hdata;
      @(posedge clock);
      tracker.set_reg(REG_FRAME_HEIGHT, hdata);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned      phase_idx, kind, left, n_samples;
      logic [FW_W-1:0]  wval;
      logic [CSR_W-1:0] wdata, hdata;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Both sides below the minimum: a 3x3 checkerboard frame, more pixels than fit.
      set_geometry(1'b1, 12'd0, 12'd1);
      for (int i = 0; i < 9; i++) send_sample((i % 2 == 0) ? 8'hFF : 8'h00);
      drain_pixels(SETTLE_CYCLES);

      // A 4x3 frame: each center owns six pixels, four come out.
      set_geometry(1'b1, 12'd4, 12'd3);
      for (int i = 0; i < 12; i++) send_sample(((i + i / 4) % 2 == 1) ? 8'hFF : 8'h00);
      drain_pixels(SETTLE_CYCLES);

      // Part of a row at the widest line, width written above the maximum; the
      // frame then narrows to four columns in mid-row and runs to its end.
      idle_mode <= IDLE_BOTH;
      set_geometry(1'b1, 12'hFFF, 12'd3);
      for (int i = 0; i < WIDE_SAMPLES; i++) send_sample(pix_type'($urandom_range(0, 255)));
      drain_pixels(SETTLE_CYCLES);
      set_geometry(1'b1, 12'd4, 12'd3);
      left = tracker.frame_left();
      for (int i = 0; i < left; i++) send_sample(pix_type'($urandom_range(0, 255)));
      drain_pixels(SETTLE_CYCLES);

      // Random phases: new geometry, often in mid-frame, and a different idle pattern.
      for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
         idle_mode <= idle_kind_type'(phase_idx % 4);
         kind = $urandom_range(0, 9);
         case (kind)
            0: begin
               wval  = FW_W'($urandom_range(0, 2));
               hdata = CSR_W'($urandom_range(3, 8));
            end
            1: begin
               wval  = FW_W'($urandom_range(3, 10));
               hdata = CSR_W'($urandom_range(0, 2));
            end
            2: begin
               wval  = FW_W'($urandom_range(3, 8));
               hdata = $urandom_range(0, 1) ? 12'hFFF : CSR_W'($urandom_range(9, 4094));
            end
            default: begin
               wval  = FW_W'($urandom_range(3, 16));
               hdata = CSR_W'($urandom_range(3, 9));
            end
         endcase
         if (phase_idx == 2) begin
            wval  = FW_W'(3);
            hdata = CSR_W'(3);
         end
         if (phase_idx == 7) hdata = 12'hFFF;
         wdata = CSR_W'(wval) | (CSR_W'($urandom_range(0, 3)) << FW_W);
         set_geometry(tracker.width_can_become(wval), wdata, hdata);

         left = tracker.frame_left();
         n_samples = ($urandom_range(0, 1) && left <= 40) ? left : $urandom_range(8, 24);

         // The result side holds off long enough for the block to back up.
         if (phase_idx == 2) begin
            hold_token <= hold_token + 1;
            n_samples = 40;
         end

         for (int k = 0; k < n_samples; k++) begin
            if (phase_idx == 5 && k == n_samples / 2) drain_pixels(0);
            send_sample(pix_type'($urandom_range(0, 255)));
         end
         drain_pixels(SETTLE_CYCLES);
      end

      drain_pixels(2 * SETTLE_CYCLES);
      if (tracker.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
